[src/dssvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssvm_pkg
// shared types and constants of the drum step sequencer and voice mixer
// ----------------------------------------------------------------------------
package dssvm_pkg;

    localparam int VOICES_DEF        = 16;
    localparam int DRUMS_DEF         = 8;
    localparam int SAMPLE_DEPTH_DEF  = 4096;
    localparam int PATTERN_STEPS_DEF = 16;

    localparam logic [15:0] MAX_INTERVAL   = 16'd44100;
    localparam logic [15:0] INTERVAL_RESET = 16'd13230;
    localparam logic [4:0]  PLEN_RESET     = 5'd16;
    localparam int          MIX_W          = 20;

    // action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_SAMPLE  = 3'd1;
    localparam logic [2:0] ACT_PATTERN = 3'd2;
    localparam logic [2:0] ACT_LENGTH  = 3'd3;
    localparam logic [2:0] ACT_TOGGLE  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_INTERVAL  = 2'd0;
    localparam logic [1:0] REG_BACKWARDS = 2'd1;
    localparam logic [1:0] REG_PLEN      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_MIX_RD,
        ST_MIX_ACC,
        ST_OUT
    } t_state;

endpackage

[src/drum_step_sequencer_voice_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_step_sequencer_voice_mixer
// step sequencer starting sample voices and mixing them into one stream
// ----------------------------------------------------------------------------
// Usage: s_axis beats carry one command each: tdata holds action, drum,
// address and value from the lowest bit up. Load and toggle commands are
// applied in the idle state and give no output beat. A tick walks a small
// sequencer: when a pattern step fires, each of the first min(DRUMS, 8)
// drum bits of the mask in turn takes the first free voice of the voice
// table, then the voices are walked one by one, each by a sample memory
// read and then the one shared adder accumulating the mix, since there is
// a single sample memory read port. The next command is taken only once
// the result beat has been taken by the receiver.
// The result beat m_axis_tdata = {step_fired, mix} waits in an output
// register; while the receiver stalls, s_axis_tready stays low.
// Reset clears voices, tempo counter, step index and play flag and sets
// the registers to their defaults; sample, length and pattern stores hold
// garbage until written. Configuration writes go through i_cfg_we.
// ----------------------------------------------------------------------------
module drum_step_sequencer_voice_mixer #(
    parameter int VOICES        = dssvm_pkg::VOICES_DEF,
    parameter int DRUMS         = dssvm_pkg::DRUMS_DEF,
    parameter int SAMPLE_DEPTH  = dssvm_pkg::SAMPLE_DEPTH_DEF,
    parameter int PATTERN_STEPS = dssvm_pkg::PATTERN_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], drum[5:3], address[17:6], value[33:18], zero pad
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mix[19:0], step_fired[20], zero pad
    output logic [23:0] m_axis_tdata
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int DW = (DRUMS > 1) ? $clog2(DRUMS) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int PW = (PATTERN_STEPS > 1) ? $clog2(PATTERN_STEPS) : 1;
    localparam int LW = AW + 1;
    localparam int MW = dssvm_pkg::MIX_W;
    localparam int NALLOC = (DRUMS < 8) ? DRUMS : 8;

    // input fields
    logic [2:0]  w_action;
    logic [2:0]  w_drum;
    logic [11:0] w_addr;
    logic [15:0] w_value;
    assign w_action = s_axis_tdata[2:0];
    assign w_drum   = s_axis_tdata[5:3];
    assign w_addr   = s_axis_tdata[17:6];
    assign w_value  = s_axis_tdata[33:18];

    // config registers
    logic [15:0] r_interval;
    logic        r_backwards;
    logic [4:0]  r_plen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= dssvm_pkg::INTERVAL_RESET;
            r_backwards <= 1'b0;
            r_plen      <= dssvm_pkg::PLEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dssvm_pkg::REG_INTERVAL:  r_interval  <= i_cfg_data;
                dssvm_pkg::REG_BACKWARDS: r_backwards <= i_cfg_data[0];
                dssvm_pkg::REG_PLEN:      r_plen      <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // stores
    logic [15:0]   m_samples [DRUMS*SAMPLE_DEPTH];
    logic [LW-1:0] r_len [DRUMS];
    logic [7:0]    r_pat [PATTERN_STEPS];

    // voice table and sequencer state
    logic [VOICES-1:0] r_active;
    logic [DW-1:0]     r_vdrum [VOICES];
    logic [AW-1:0]     r_vpos  [VOICES];
    logic [15:0]       r_tempo;
    logic [PW-1:0]     r_step;
    logic              r_playing;
    dssvm_pkg::t_state r_state, n_state;
    logic [VW-1:0]     r_vi;
    logic [2:0]        r_di;
    logic [7:0]        r_mask;
    logic              r_fired;
    logic [MW-1:0]     r_acc;
    logic [15:0]       r_rd;
    logic              r_ovalid;
    logic [MW:0]       r_odata;

    logic w_accept;
    assign s_axis_tready = (r_state == dssvm_pkg::ST_IDLE) && !r_ovalid;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // clamped interval and pattern length
    logic [15:0] w_target;
    logic [8:0]  w_plen;
    always_comb begin
        w_target = r_interval;
        if (w_target == 16'd0) w_target = 16'd1;
        if (w_target > dssvm_pkg::MAX_INTERVAL) w_target = dssvm_pkg::MAX_INTERVAL;
        w_plen = {4'd0, r_plen};
        if (w_plen == 9'd0) w_plen = 9'd1;
        if (w_plen > 9'(PATTERN_STEPS)) w_plen = 9'(PATTERN_STEPS);
    end

    // first free voice
    logic          w_free_hit;
    logic [VW-1:0] w_free;
    always_comb begin
        w_free_hit = 1'b0;
        w_free = '0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_active[v]) begin
                w_free_hit = 1'b1;
                w_free = VW'(v);
            end
        end
    end

    logic w_fire;
    assign w_fire = r_playing && (r_tempo == w_target - 16'd1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dssvm_pkg::ST_IDLE:
                if (w_accept && w_action == dssvm_pkg::ACT_TICK)
                    n_state = w_fire ? dssvm_pkg::ST_ALLOC : dssvm_pkg::ST_MIX_RD;
            dssvm_pkg::ST_ALLOC:
                if (r_di == 3'(NALLOC - 1)) n_state = dssvm_pkg::ST_MIX_RD;
            dssvm_pkg::ST_MIX_RD:  n_state = dssvm_pkg::ST_MIX_ACC;
            dssvm_pkg::ST_MIX_ACC:
                if (r_vi == VW'(VOICES - 1)) n_state = dssvm_pkg::ST_OUT;
                else n_state = dssvm_pkg::ST_MIX_RD;
            dssvm_pkg::ST_OUT:     n_state = dssvm_pkg::ST_IDLE;
            default:               n_state = dssvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= dssvm_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // sample memory port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_action == dssvm_pkg::ACT_SAMPLE &&
            32'(w_drum) < DRUMS && 32'(w_addr) < SAMPLE_DEPTH)
            m_samples[{DW'(w_drum), AW'(w_addr)}] <= w_value;
        r_rd <= m_samples[{r_vdrum[r_vi], r_vpos[r_vi]}];
    end

    // length and pattern stores
    logic [15:0] w_lensat;
    always_comb begin
        w_lensat = w_value;
        if (w_lensat == 16'd0) w_lensat = 16'd1;
        if (32'(w_lensat) > SAMPLE_DEPTH) w_lensat = 16'(SAMPLE_DEPTH);
    end
    always_ff @(posedge i_clk) begin
        if (w_accept && w_action == dssvm_pkg::ACT_LENGTH && 32'(w_drum) < DRUMS)
            r_len[DW'(w_drum)] <= LW'(w_lensat);
        if (w_accept && w_action == dssvm_pkg::ACT_PATTERN &&
            32'(w_addr) < PATTERN_STEPS)
            r_pat[w_addr[PW-1:0]] <= w_value[7:0];
    end

    // current voice length for the end test
    logic [LW-1:0] w_vlen;
    logic [LW-1:0] w_pos1;
    assign w_vlen = r_len[r_vdrum[r_vi]];
    assign w_pos1 = {1'b0, r_vpos[r_vi]} + LW'(1);

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_vdrum[v] <= '0;
                r_vpos[v]  <= '0;
            end
            r_tempo   <= '0;
            r_step    <= '0;
            r_playing <= 1'b0;
            r_vi      <= '0;
            r_di      <= '0;
            r_mask    <= '0;
            r_fired   <= 1'b0;
            r_acc     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                dssvm_pkg::ST_IDLE: begin
                    r_vi  <= '0;
                    r_di  <= '0;
                    r_acc <= '0;
                    if (w_accept && w_action == dssvm_pkg::ACT_TOGGLE) begin
                        r_playing <= !r_playing;
                        r_tempo   <= '0;
                    end
                    if (w_accept && w_action == dssvm_pkg::ACT_TICK) begin
                        r_fired <= w_fire;
                        if (w_fire) begin
                            r_tempo <= '0;
                            r_mask  <= r_pat[r_step];
                            if (32'(r_step) + 1 >= 32'(w_plen)) r_step <= '0;
                            else r_step <= r_step + PW'(1);
                        end else if (r_tempo + 16'd1 >= dssvm_pkg::MAX_INTERVAL) begin
                            r_tempo <= '0;
                        end else begin
                            r_tempo <= r_tempo + 16'd1;
                        end
                    end
                end
                dssvm_pkg::ST_ALLOC: begin
                    // one drum bit a cycle takes the first free voice
                    if (r_mask[r_di] && w_free_hit) begin
                        r_active[w_free] <= 1'b1;
                        r_vdrum[w_free]  <= DW'(r_di);
                        if (r_backwards) begin
                            r_vpos[w_free] <= AW'(r_len[DW'(r_di)] - LW'(1));
                        end else begin
                            r_vpos[w_free] <= '0;
                        end
                    end
                    r_di <= r_di + 3'd1;
                end
                dssvm_pkg::ST_MIX_RD: ;
                dssvm_pkg::ST_MIX_ACC: begin
                    // shared accumulator, one voice a pass
                    if (r_active[r_vi]) begin
                        r_acc <= r_acc + MW'({{(MW-16){r_rd[15]}}, r_rd});
                        if (r_backwards) begin
                            if (r_vpos[r_vi] <= AW'(1)) begin
                                r_active[r_vi] <= 1'b0;
                                r_vpos[r_vi]   <= '0;
                            end else begin
                                r_vpos[r_vi] <= r_vpos[r_vi] - AW'(1);
                            end
                        end else if (w_pos1 >= w_vlen) begin
                            r_active[r_vi] <= 1'b0;
                            r_vpos[r_vi]   <= '0;
                        end else begin
                            r_vpos[r_vi] <= w_pos1[AW-1:0];
                        end
                    end
                    if (r_vi != VW'(VOICES - 1)) r_vi <= r_vi + VW'(1);
                end
                dssvm_pkg::ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {r_fired, r_acc};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_odata};

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dssvm_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while sequencer busy");
    a_out_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dssvm_pkg::ST_OUT) |=> r_ovalid)
        else $error("result not posted after voice walk");
    a_tempo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tempo < dssvm_pkg::MAX_INTERVAL)
        else $error("tempo counter out of range");
endmodule
